// ===== rtl/core/phsp_pkg.sv =====
// Package for the PNG header stream parser: phase, status and format codes,
// signature and tag tables, and the format classification function.
// No dependencies.
package phsp_pkg;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SIG,
		PH_LEN,
		PH_TAG,
		PH_FIELDS,
		PH_PSEARCH,
		PH_PSKIP,
		PH_DSEARCH,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIG   = 2'd1,
		ST_BAD_TAG   = 2'd2,
		ST_EARLY_END = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FMT_OK          = 2'd0,
		FMT_UNSUPPORTED = 2'd1,
		FMT_INVALID     = 2'd2
	} fmt_t;

	localparam logic [31:0] SIG_END    = 32'd8;
	localparam logic [31:0] LEN_END    = 32'd12;
	localparam logic [31:0] TAG_END    = 32'd16;
	localparam logic [31:0] FIELDS_END = 32'd29;
	localparam logic [7:0]  PALETTE_TYPE = 8'd3;
	localparam logic [7:0]  DEPTH_OK     = 8'd8;

	localparam logic [7:0] SIG_TAB [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};
	localparam logic [7:0] IHDR_TAB [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
	localparam logic [7:0] IDAT_TAB [4] = '{8'h49, 8'h44, 8'h41, 8'h54};
	localparam logic [7:0] PLTE_TAB [4] = '{8'h50, 8'h4C, 8'h54, 8'h45};

	function automatic fmt_t classify(input logic [7:0] depth, input logic [7:0] ctype);
		fmt_t f;
		if (depth != DEPTH_OK) begin
			f = FMT_UNSUPPORTED;
		end else if (ctype == 8'd0 || ctype == 8'd2 || ctype == 8'd3) begin
			f = FMT_OK;
		end else if (ctype == 8'd4 || ctype == 8'd6) begin
			f = FMT_UNSUPPORTED;
		end else begin
			f = FMT_INVALID;
		end
		return f;
	endfunction

endpackage

// ===== rtl/core/phsp_if.sv =====
// Stream interfaces of the PNG header stream parser: byte beats in,
// header result beats out. Depends on nothing.
interface phsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_file;
	logic       end_of_file;

	modport source(output valid, data_byte, first_of_file, end_of_file, input ready);
	modport sink(input valid, data_byte, first_of_file, end_of_file, output ready);
endinterface

interface phsp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  format_status;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [7:0]  bit_depth;
	logic [7:0]  colour_type;
	logic [7:0]  compression_method;
	logic [7:0]  filter_method;
	logic [7:0]  interlace_method;
	logic [31:0] palette_length;
	logic [31:0] data_length;

	modport source(output valid, status, format_status, image_width, image_height,
		bit_depth, colour_type, compression_method, filter_method, interlace_method,
		palette_length, data_length, input ready);
	modport sink(input valid, status, format_status, image_width, image_height,
		bit_depth, colour_type, compression_method, filter_method, interlace_method,
		palette_length, data_length, output ready);
endinterface

// ===== rtl/core/phsp_tag_match.sv =====
// Four-byte chunk tag matcher for the PLTE and IDAT searches.
// Depends on phsp_pkg.
module phsp_tag_match (
	input  logic [1:0] count,
	input  logic [7:0] data_byte,
	input  logic       sel_idat,
	output logic [1:0] count_next,
	output logic       hit
);
	import phsp_pkg::*;

	logic [7:0] tab_cur;
	logic [7:0] tab_first;
	logic       eq_cur;

	always_comb begin
		tab_cur   = sel_idat ? IDAT_TAB[count] : PLTE_TAB[count];
		tab_first = sel_idat ? IDAT_TAB[0] : PLTE_TAB[0];
		eq_cur    = (data_byte == tab_cur);
		hit       = eq_cur && (count == 2'd3);
		if (eq_cur) begin
			count_next = count + 2'd1;
		end else begin
			count_next = (data_byte == tab_first) ? 2'd1 : 2'd0;
		end
	end
endmodule

// ===== rtl/core/png_header_stream_parser.sv =====
// PNG header stream parser: top level with input stage, parse logic and
// result register. Depends on phsp_pkg, phsp_if and phsp_tag_match.
//
// Usage:
//   stream carries one file byte per beat; first_of_file restarts parsing
//   on that byte, end_of_file marks the last byte. Bytes seen while idle or
//   after a result, without first_of_file, are dropped.
//   result carries at most one beat per file: success at the last IDAT tag
//   byte, or the first error, or an early end at the end_of_file byte.
// Order: the byte beat that causes a result is held in the input register,
//   and the result is then captured in the result register.
// Throughput: one byte per cycle unless a result is stalled; the parse step is
//   one compare, shift or 32-bit decrement between input and result registers.
// Stall: while a result waits on result.ready, the input register holds its
//   byte and stream.ready drops once that register is full.
// Reset: arst_n clears all parse state to idle and empties both registers;
//   the first byte after reset must carry first_of_file.
module png_header_stream_parser (
	input logic          clk,
	input logic          arst_n,
	phsp_in_if.sink      stream,
	phsp_out_if.source   result
);
	import phsp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;

	phase_t      phase_q;
	logic [31:0] cnt_q;
	logic [55:0] recent_q;
	logic [1:0]  tmc_q;
	logic [31:0] width_q;
	logic [31:0] height_q;
	logic [39:0] hdr_q;
	logic [31:0] plen_q;

	phase_t      cur_phase, nxt_phase;
	logic [31:0] cur_cnt, nxt_cnt;
	logic [55:0] cur_recent, nxt_recent;
	logic [1:0]  cur_tmc, nxt_tmc;
	logic [31:0] cur_width, nxt_width;
	logic [31:0] cur_height, nxt_height;
	logic [39:0] cur_hdr, nxt_hdr;
	logic [31:0] cur_plen, nxt_plen;
	logic [63:0] shifted;
	logic [31:0] len_word;
	logic        active;
	logic        res_valid;
	status_t     res_status;
	fmt_t        res_fmt;
	logic [31:0] res_dlen;
	logic [1:0]  tag_cnt_next;
	logic        tag_hit;
	logic        proc_en;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [1:0]  out_fmt_q;
	logic [31:0] out_width_q;
	logic [31:0] out_height_q;
	logic [39:0] out_hdr_q;
	logic [31:0] out_plen_q;
	logic [31:0] out_dlen_q;

	assign proc_en      = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || proc_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1  <= stream.data_byte;
			first_s1 <= stream.first_of_file;
			last_s1  <= stream.end_of_file;
		end
	end

	phsp_tag_match u_tag (
		.count      (cur_tmc),
		.data_byte  (byte_s1),
		.sel_idat   (cur_phase == PH_DSEARCH),
		.count_next (tag_cnt_next),
		.hit        (tag_hit)
	);

	always_comb begin
		cur_phase  = first_s1 ? PH_SIG : phase_q;
		cur_cnt    = first_s1 ? '0 : cnt_q;
		cur_recent = first_s1 ? '0 : recent_q;
		cur_tmc    = first_s1 ? '0 : tmc_q;
		cur_width  = first_s1 ? '0 : width_q;
		cur_height = first_s1 ? '0 : height_q;
		cur_hdr    = first_s1 ? '0 : hdr_q;
		cur_plen   = first_s1 ? '0 : plen_q;

		nxt_phase  = cur_phase;
		nxt_cnt    = cur_cnt;
		nxt_recent = cur_recent;
		nxt_tmc    = cur_tmc;
		nxt_width  = cur_width;
		nxt_height = cur_height;
		nxt_hdr    = cur_hdr;
		nxt_plen   = cur_plen;
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_dlen   = '0;

		shifted  = {cur_recent, byte_s1};
		len_word = shifted[63:32];
		active   = (cur_phase != PH_IDLE) && (cur_phase != PH_DONE);

		if (active) begin
			nxt_recent = shifted[55:0];
		end

		unique case (cur_phase)
			PH_SIG: begin
				if (byte_s1 != SIG_TAB[cur_cnt[2:0]]) begin
					res_valid  = 1'b1;
					res_status = ST_BAD_SIG;
				end else begin
					nxt_cnt = cur_cnt + 32'd1;
					if (nxt_cnt == SIG_END) begin
						nxt_phase = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				nxt_cnt = cur_cnt + 32'd1;
				if (nxt_cnt == LEN_END) begin
					nxt_phase = PH_TAG;
				end
			end
			PH_TAG: begin
				if (byte_s1 != IHDR_TAB[cur_cnt[1:0]]) begin
					res_valid  = 1'b1;
					res_status = ST_BAD_TAG;
				end else begin
					nxt_cnt = cur_cnt + 32'd1;
					if (nxt_cnt == TAG_END) begin
						nxt_phase = PH_FIELDS;
					end
				end
			end
			PH_FIELDS: begin
				if (cur_cnt[3:0] < 4'd4) begin
					nxt_width = {cur_width[23:0], byte_s1};
				end else if (cur_cnt[3:0] < 4'd8) begin
					nxt_height = {cur_height[23:0], byte_s1};
				end else begin
					nxt_hdr = {cur_hdr[31:0], byte_s1};
				end
				nxt_cnt = cur_cnt + 32'd1;
				if (nxt_cnt == FIELDS_END) begin
					nxt_tmc   = '0;
					nxt_phase = (nxt_hdr[31:24] == PALETTE_TYPE) ? PH_PSEARCH : PH_DSEARCH;
				end
			end
			PH_PSEARCH: begin
				nxt_tmc = tag_hit ? 2'd0 : tag_cnt_next;
				if (tag_hit) begin
					nxt_plen = len_word;
					if (len_word == 32'd0) begin
						nxt_phase = PH_DSEARCH;
					end else begin
						nxt_cnt   = len_word;
						nxt_phase = PH_PSKIP;
					end
				end
			end
			PH_PSKIP: begin
				nxt_cnt = cur_cnt - 32'd1;
				if (nxt_cnt == 32'd0) begin
					nxt_tmc   = '0;
					nxt_phase = PH_DSEARCH;
				end
			end
			PH_DSEARCH: begin
				nxt_tmc = tag_hit ? 2'd0 : tag_cnt_next;
				if (tag_hit) begin
					res_valid  = 1'b1;
					res_status = ST_OK;
					res_dlen   = len_word;
				end
			end
			PH_IDLE, PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (active && !res_valid && last_s1) begin
			res_valid  = 1'b1;
			res_status = ST_EARLY_END;
		end
		if (res_valid) begin
			nxt_phase = PH_DONE;
		end
	end

	always_comb begin
		res_fmt = (res_status == ST_OK) ? classify(nxt_hdr[39:32], nxt_hdr[31:24]) : FMT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			recent_q <= '0;
			tmc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			hdr_q    <= '0;
			plen_q   <= '0;
		end else if (proc_en) begin
			phase_q  <= nxt_phase;
			cnt_q    <= nxt_cnt;
			recent_q <= nxt_recent;
			tmc_q    <= nxt_tmc;
			width_q  <= nxt_width;
			height_q <= nxt_height;
			hdr_q    <= nxt_hdr;
			plen_q   <= nxt_plen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_en && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en && res_valid) begin
			out_status_q <= res_status;
			out_fmt_q    <= res_fmt;
			out_width_q  <= nxt_width;
			out_height_q <= nxt_height;
			out_hdr_q    <= nxt_hdr;
			out_plen_q   <= nxt_plen;
			out_dlen_q   <= res_dlen;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.status             = out_status_q;
	assign result.format_status      = out_fmt_q;
	assign result.image_width        = out_width_q;
	assign result.image_height       = out_height_q;
	assign result.bit_depth          = out_hdr_q[39:32];
	assign result.colour_type        = out_hdr_q[31:24];
	assign result.compression_method = out_hdr_q[23:16];
	assign result.filter_method      = out_hdr_q[15:8];
	assign result.interlace_method   = out_hdr_q[7:0];
	assign result.palette_length     = out_plen_q;
	assign result.data_length        = out_dlen_q;
endmodule

// ===== rtl/core/phsp_checker.sv =====
// Port-level checks on the result channel of png_header_stream_parser,
// bound to the top level. Depends on phsp_pkg.
module phsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [1:0]  format_status,
	input logic [31:0] image_width,
	input logic [31:0] image_height,
	input logic [7:0]  bit_depth,
	input logic [31:0] palette_length,
	input logic [31:0] data_length
);
	import phsp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_length))
		else $error("result beat changed while stalled");

	a_fmt_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> format_status != 2'd3)
		else $error("format status out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> format_status == FMT_OK && data_length == 32'd0)
		else $error("error result carries format or data length");

	a_early_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD_SIG || status == ST_BAD_TAG)
		|-> image_width == 32'd0 && image_height == 32'd0 && bit_depth == 8'd0
			&& palette_length == 32'd0)
		else $error("header fields captured before IHDR was reached");
endmodule

bind png_header_stream_parser phsp_checker u_phsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.status         (result.status),
	.format_status  (result.format_status),
	.image_width    (result.image_width),
	.image_height   (result.image_height),
	.bit_depth      (result.bit_depth),
	.palette_length (result.palette_length),
	.data_length    (result.data_length)
);

// ===== sim/png_header_stream_parser_checker.sv =====
// Checker for png_header_stream_parser: watches the byte and result channels,
// predicts each header result from the accepted bytes and compares it field by field.
// Depends on phsp_pkg and phsp_if.
`timescale 1ns / 1ps

module png_header_stream_parser_checker (
	input logic clk,
	input logic arst_n,
	phsp_in_if  stream,
	phsp_out_if result,
	output int  fails,
	output int  outstanding
);
	import phsp_pkg::*;

	localparam logic [7:0] CT_GREY       = 8'd0;
	localparam logic [7:0] CT_RGB        = 8'd2;
	localparam logic [7:0] CT_GREY_ALPHA = 8'd4;
	localparam logic [7:0] CT_RGBA       = 8'd6;

	typedef struct packed {
		status_t     status;
		fmt_t        fmt;
		logic [31:0] width;
		logic [31:0] height;
		logic [7:0]  depth;
		logic [7:0]  ctype;
		logic [7:0]  compression;
		logic [7:0]  filter;
		logic [7:0]  interlace;
		logic [31:0] palette_len;
		logic [31:0] data_len;
	} header_result_t;

	phase_t      phase;
	logic [31:0] byte_cnt;
	logic [63:0] history;
	logic [2:0]  match_cnt;
	logic [31:0] width_acc;
	logic [31:0] height_acc;
	logic [39:0] method_bytes;
	logic [31:0] pal_len;

	header_result_t expected_headers[$];
	int mismatches = 0;

	function automatic void clear_state();
		phase = PH_IDLE;
		byte_cnt = '0;
		history = '0;
		match_cnt = '0;
		width_acc = '0;
		height_acc = '0;
		method_bytes = '0;
		pal_len = '0;
	endfunction

	function automatic bit tag_hit(input logic [7:0] tab [4], input logic [7:0] b);
		logic [1:0] pos;
		pos = match_cnt[1:0];
		if (b == tab[pos]) begin
			match_cnt = {1'b0, pos} + 3'd1;
		end else begin
			match_cnt = (b == tab[0]) ? 3'd1 : 3'd0;
		end
		if (match_cnt == 3'd4) begin
			match_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic fmt_t format_of(input logic [7:0] depth, input logic [7:0] ctype);
		if (depth != DEPTH_OK)
			return FMT_UNSUPPORTED;
		if (ctype == CT_GREY || ctype == CT_RGB || ctype == PALETTE_TYPE)
			return FMT_OK;
		if (ctype == CT_GREY_ALPHA || ctype == CT_RGBA)
			return FMT_UNSUPPORTED;
		return FMT_INVALID;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic first, input logic last,
			output bit produced, output header_result_t res);
		logic [31:0] offset;
		logic [31:0] idat_len;
		bit done;
		status_t code;
		produced = 1'b0;
		res = '0;
		done = 1'b0;
		code = ST_OK;
		idat_len = '0;
		if (first) begin
			clear_state();
			phase = PH_SIG;
		end
		if (phase == PH_IDLE || phase == PH_DONE)
			return;
		history = {history[55:0], b};
		case (phase)
		PH_SIG: begin
			if (b != SIG_TAB[byte_cnt[2:0]]) begin
				done = 1'b1;
				code = ST_BAD_SIG;
			end else begin
				byte_cnt++;
				if (byte_cnt >= SIG_END)
					phase = PH_LEN;
			end
		end
		PH_LEN: begin
			byte_cnt++;
			if (byte_cnt >= LEN_END)
				phase = PH_TAG;
		end
		PH_TAG: begin
			offset = byte_cnt - LEN_END;
			if (b != IHDR_TAB[offset[1:0]]) begin
				done = 1'b1;
				code = ST_BAD_TAG;
			end else begin
				byte_cnt++;
				if (byte_cnt >= TAG_END)
					phase = PH_FIELDS;
			end
		end
		PH_FIELDS: begin
			offset = byte_cnt - TAG_END;
			if (offset < 4)
				width_acc = {width_acc[23:0], b};
			else if (offset < 8)
				height_acc = {height_acc[23:0], b};
			else
				method_bytes = {method_bytes[31:0], b};
			byte_cnt++;
			if (byte_cnt >= FIELDS_END) begin
				match_cnt = '0;
				phase = (method_bytes[31:24] == PALETTE_TYPE) ? PH_PSEARCH : PH_DSEARCH;
			end
		end
		PH_PSEARCH: begin
			if (tag_hit(PLTE_TAB, b)) begin
				pal_len = history[63:32];
				if (pal_len == 0) begin
					phase = PH_DSEARCH;
				end else begin
					byte_cnt = pal_len;
					phase = PH_PSKIP;
				end
			end
		end
		PH_PSKIP: begin
			byte_cnt--;
			if (byte_cnt == 0) begin
				match_cnt = '0;
				phase = PH_DSEARCH;
			end
		end
		default: begin
			if (tag_hit(IDAT_TAB, b)) begin
				idat_len = history[63:32];
				done = 1'b1;
				code = ST_OK;
			end
		end
		endcase
		if (!done && last) begin
			done = 1'b1;
			code = ST_EARLY_END;
		end
		if (!done)
			return;
		phase = PH_DONE;
		produced = 1'b1;
		res.status = code;
		res.fmt = (code == ST_OK) ? format_of(method_bytes[39:32], method_bytes[31:24]) : FMT_OK;
		res.width = width_acc;
		res.height = height_acc;
		res.depth = method_bytes[39:32];
		res.ctype = method_bytes[31:24];
		res.compression = method_bytes[23:16];
		res.filter = method_bytes[15:8];
		res.interlace = method_bytes[7:0];
		res.palette_len = pal_len;
		res.data_len = idat_len;
	endtask

	function automatic void check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, label, want, got);
		end
	endfunction

	initial clear_state();

	always @(posedge clk) begin
		header_result_t want;
		bit produced;
		if (!arst_n) begin
			clear_state();
			expected_headers.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_headers.size() == 0) begin
					mismatches++;
					$display("%0t: result beat expected none, actual status %0h",
						$time, result.status);
				end else begin
					want = expected_headers.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("format_status", 32'(want.fmt), 32'(result.format_status));
					check_field("image_width", want.width, result.image_width);
					check_field("image_height", want.height, result.image_height);
					check_field("bit_depth", 32'(want.depth), 32'(result.bit_depth));
					check_field("colour_type", 32'(want.ctype), 32'(result.colour_type));
					check_field("compression_method", 32'(want.compression),
						32'(result.compression_method));
					check_field("filter_method", 32'(want.filter),
						32'(result.filter_method));
					check_field("interlace_method", 32'(want.interlace),
						32'(result.interlace_method));
					check_field("palette_length", want.palette_len, result.palette_length);
					check_field("data_length", want.data_len, result.data_length);
				end
			end
			if (stream.valid && stream.ready) begin
				parse_byte(stream.data_byte, stream.first_of_file, stream.end_of_file,
					produced, want);
				if (produced)
					expected_headers.push_back(want);
			end
		end
		fails <= mismatches;
		outstanding <= expected_headers.size();
	end

endmodule

// ===== sim/png_header_stream_parser_tb.sv =====
// Testbench top for png_header_stream_parser: builds PNG-like byte files, some broken,
// drives them with random gaps against random result stalls and gives the verdict.
// Depends on phsp_pkg, phsp_if, the parser RTL and png_header_stream_parser_checker.
`timescale 1ns / 1ps

module png_header_stream_parser_tb;
	import phsp_pkg::*;

	localparam int ITEM_TARGET = 1100;
	localparam int MIN_FILES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SKIP_CAP = 40;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [31:0] IHDR_LEN = 32'd13;

	typedef enum {
		FILE_GOOD,
		FILE_BAD_SIG,
		FILE_BAD_TAG,
		FILE_CUT_EOF,
		FILE_CUT_RESTART,
		FILE_JUNK
	} file_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} byte_beat_t;

	logic clk;
	logic arst_n;
	int fails;
	int outstanding;
	int cycle_cnt = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int pick;
	file_kind_t kind;
	byte_beat_t file_q[$];

	phsp_in_if  stream();
	phsp_out_if result();

	png_header_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.result(result)
	);

	png_header_stream_parser_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.result(result),
		.fails(fails),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL png_header_stream_parser");
			$finish;
		end
	end

	initial begin
		int stall_left;
		int mode_left;
		bit calm;
		stall_left = 0;
		mode_left = 0;
		calm = 1'b0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 2);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b);
		file_q.push_back(byte_beat_t'{data: b, first: 1'b0, last: 1'b0});
	endtask

	task automatic put_word(input logic [31:0] w);
		put_byte(w[31:24]);
		put_byte(w[23:16]);
		put_byte(w[15:8]);
		put_byte(w[7:0]);
	endtask

	task automatic put_tag(input logic [7:0] tab [4]);
		for (int i = 0; i < 4; i++)
			put_byte(tab[i]);
	endtask

	task automatic put_noise(input logic [7:0] lead);
		repeat ($urandom_range(0, 5))
			put_byte(8'($urandom));
		if ($urandom_range(0, 3) == 0)
			put_byte(lead);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2: return $urandom_range(1, 4096);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_depth();
		case ($urandom_range(0, 7))
		0, 1, 2, 3: return DEPTH_OK;
		4, 5: return 8'($urandom_range(0, 16));
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_colour();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return PALETTE_TYPE;
		9: return 8'($urandom);
		default: return 8'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [31:0] pick_palette();
		case ($urandom_range(0, 19))
		0, 1, 2: return 32'd0;
		3: return $urandom;
		default: return $urandom_range(1, 24);
		endcase
	endfunction

	function automatic int pick_gap();
		case ($urandom_range(0, 19))
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: return 0;
		11, 12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
		18: return $urandom_range(4, 9);
		default: return $urandom_range(10, 40);
		endcase
	endfunction

	task automatic build_png();
		logic [7:0] ctype;
		logic [31:0] pal;
		int skip;
		for (int i = 0; i < 8; i++)
			put_byte(SIG_TAB[i]);
		put_word(($urandom_range(0, 3) == 0) ? $urandom : IHDR_LEN);
		put_tag(IHDR_TAB);
		put_word(pick_word());
		put_word(pick_word());
		put_byte(pick_depth());
		ctype = pick_colour();
		put_byte(ctype);
		repeat (3)
			put_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)));
		if (ctype == PALETTE_TYPE) begin
			pal = pick_palette();
			put_noise(PLTE_TAB[0]);
			put_word(pal);
			put_tag(PLTE_TAB);
			skip = (pal > SKIP_CAP) ? SKIP_CAP : int'(pal);
			repeat (skip)
				put_byte(8'($urandom));
		end
		put_noise(IDAT_TAB[0]);
		put_word(pick_word());
		if ($urandom_range(0, 4) == 0)
			put_byte(IDAT_TAB[0]);
		put_tag(IDAT_TAB);
	endtask

	task automatic cut_to(input int keep);
		while (file_q.size() > keep)
			void'(file_q.pop_back());
	endtask

	task automatic make_file(input file_kind_t k);
		int idx;
		file_q.delete();
		if (k == FILE_JUNK) begin
			repeat ($urandom_range(1, 6))
				put_byte(8'($urandom));
			file_q[file_q.size() - 1].last = 1'($urandom_range(0, 1));
			return;
		end
		build_png();
		file_q[0].first = 1'b1;
		case (k)
		FILE_GOOD: begin
			case ($urandom_range(0, 2))
			0: file_q[file_q.size() - 1].last = 1'b1;
			1: begin
				repeat ($urandom_range(1, 3))
					put_byte(8'($urandom));
				file_q[file_q.size() - 1].last = 1'b1;
			end
			default: ;
			endcase
		end
		FILE_BAD_SIG, FILE_BAD_TAG: begin
			idx = (k == FILE_BAD_SIG) ? $urandom_range(0, 7) : $urandom_range(12, 15);
			file_q[idx].data = file_q[idx].data ^ 8'($urandom_range(1, 255));
			cut_to(idx + 1 + $urandom_range(0, 3));
			file_q[file_q.size() - 1].last = 1'($urandom_range(0, 1));
		end
		FILE_CUT_EOF: begin
			cut_to($urandom_range(1, file_q.size()));
			file_q[file_q.size() - 1].last = 1'b1;
		end
		default: begin
			cut_to($urandom_range(1, file_q.size()));
		end
		endcase
	endtask

	task automatic send_file(input bit counted);
		bit with_gaps;
		int gap;
		with_gaps = ($urandom_range(0, 3) != 0);
		foreach (file_q[i]) begin
			stream.valid <= 1'b1;
			stream.data_byte <= file_q[i].data;
			stream.first_of_file <= file_q[i].first;
			stream.end_of_file <= file_q[i].last;
			@(posedge clk);
			while (!stream.ready)
				@(posedge clk);
			if (counted)
				bytes_sent++;
			gap = with_gaps ? pick_gap() : 0;
			if (gap > 0) begin
				stream.valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
	endtask

	task automatic send_single(input logic [7:0] b, input logic first, input logic last);
		file_q.delete();
		put_byte(b);
		file_q[0].first = first;
		file_q[0].last = last;
		send_file(1'b1);
	endtask

	task automatic drain_results();
		stream.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		stream.valid <= 1'b0;
		stream.data_byte <= 8'h00;
		stream.first_of_file <= 1'b0;
		stream.end_of_file <= 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_single(SIG_TAB[0], 1'b0, 1'b1);
		send_single(8'hFF, 1'b1, 1'b1);
		send_single(SIG_TAB[0], 1'b1, 1'b1);
		send_single(8'h00, 1'b1, 1'b0);
		file_q.delete();
		for (int i = 0; i < 7; i++)
			put_byte(SIG_TAB[i]);
		put_byte(~SIG_TAB[7]);
		file_q[0].first = 1'b1;
		send_file(1'b1);
		file_q.delete();
		for (int i = 0; i < 8; i++)
			put_byte(SIG_TAB[i]);
		put_word(32'hFFFF_FFFF);
		file_q[0].first = 1'b1;
		file_q[file_q.size() - 1].last = 1'b1;
		send_file(1'b1);
		drain_results();

		while (bytes_sent < ITEM_TARGET || files_sent < MIN_FILES) begin
			pick = $urandom_range(0, 99);
			if (pick < 58)
				kind = FILE_GOOD;
			else if (pick < 66)
				kind = FILE_BAD_SIG;
			else if (pick < 74)
				kind = FILE_BAD_TAG;
			else if (pick < 86)
				kind = FILE_CUT_EOF;
			else if (pick < 94)
				kind = FILE_CUT_RESTART;
			else
				kind = FILE_JUNK;
			make_file(kind);
			send_file(kind != FILE_JUNK);
			if (kind != FILE_JUNK)
				files_sent++;
			if ($urandom_range(0, 19) == 0)
				drain_results();
		end

		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (fails == 0)
			$display("PASS png_header_stream_parser");
		else
			$display("FAIL png_header_stream_parser");
		$finish;
	end

endmodule

// ===== png_header_stream_parser.f =====
rtl/core/phsp_pkg.sv
rtl/core/phsp_if.sv
rtl/core/phsp_tag_match.sv
rtl/core/png_header_stream_parser.sv
rtl/core/phsp_checker.sv
sim/png_header_stream_parser_checker.sv
sim/png_header_stream_parser_tb.sv
